// ===== sv/wmsq_pkg.sv =====
// ----------------------------------------------------------------------------
// wmsq_pkg
// Shared constants, codes, command/status types and the case fold for the
// streaming wildcard matcher.
// ----------------------------------------------------------------------------
package wmsq_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int MAX_TEXT    = 511;
  localparam int ADDR_W      = $clog2(MAX_PATTERN);
  localparam int POS_W       = $clog2(MAX_PATTERN + 1);
  localparam int CNT_W       = 10;
  localparam int SCORE_W     = 10;
  localparam int STEP_LIMIT  = 2 * MAX_PATTERN + 8;
  localparam int STEP_W      = $clog2(STEP_LIMIT + 2);
  localparam int SCORE_MAX   = (1 << SCORE_W) - 1;

  // input transaction modes
  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_TEXT   = 2'd2;
  localparam logic [1:0] MODE_END    = 2'd3;

  // matching phases
  localparam logic [1:0] PH_NORMAL  = 2'd0;
  localparam logic [1:0] PH_SCAN    = 2'd1;
  localparam logic [1:0] PH_DECIDED = 2'd2;
  localparam logic [1:0] PH_FAILED  = 2'd3;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_QMARK  = 8'h3F;

  // datapath operations
  localparam logic [3:0] OP_NONE   = 4'd0;
  localparam logic [3:0] OP_CLEAR  = 4'd1;
  localparam logic [3:0] OP_APPEND = 4'd2;
  localparam logic [3:0] OP_END    = 4'd3;
  localparam logic [3:0] OP_TEXT   = 4'd4;
  localparam logic [3:0] OP_CHK    = 4'd5;
  localparam logic [3:0] OP_EV     = 4'd6;
  localparam logic [3:0] OP_QLD    = 4'd7;
  localparam logic [3:0] OP_LIT    = 4'd8;
  localparam logic [3:0] OP_SEV    = 4'd9;

  typedef struct packed {
    logic [3:0] op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] phase;
    logic       step_over;
    logic       pos_ge_len;
    logic       p_qmark;
    logic       p_star;
    logic       p_bslash;
    logic       star_last;
    logic       lit_eq;
    logic       after_star;
    logic       has_fb;
  } sts_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) r = c - 8'd32;
    return r;
  endfunction

endpackage

// ===== sv/wmsq_dp.sv =====
// ----------------------------------------------------------------------------
// wmsq_dp
// Pattern memory, match position/fallback registers, counters and the
// result register. Performs one operation per cycle as commanded.
// ----------------------------------------------------------------------------
module wmsq_dp (
  input  logic            clk,
  input  logic            rst_n,
  input  wmsq_pkg::cmd_t  cmd,
  input  logic [7:0]      char_in,
  output wmsq_pkg::sts_t  sts,
  output logic            matched,
  output logic [9:0]      score
);
  import wmsq_pkg::*;

  logic [7:0]         mem [MAX_PATTERN];
  logic [7:0]         rdata_r;

  logic [POS_W-1:0]   len_r, len_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [POS_W-1:0]   fb_r, fb_nxt;
  logic               has_fb_r, has_fb_nxt;
  logic [CNT_W-1:0]   lit_r, lit_nxt;
  logic [CNT_W-1:0]   saved_r, saved_nxt;
  logic               match_r, match_nxt;
  logic               after_r, after_nxt;
  logic [1:0]         phase_r, phase_nxt;
  logic [SCORE_W-1:0] decided_r, decided_nxt;
  logic [STEP_W-1:0]  steps_r, steps_nxt;
  logic [7:0]         uc_r, uc_nxt;
  logic [7:0]         litp_r, litp_nxt;
  logic               omatch_r, omatch_nxt;
  logic [SCORE_W-1:0] oscore_r, oscore_nxt;

  logic [CNT_W:0]     sum;
  logic [SCORE_W-1:0] calc;
  logic               pos_ge_len;
  logic [POS_W-1:0]   pos_inc;
  logic [POS_W:0]     pos_inc_w;
  logic               star_last;
  logic [7:0]         rd_pat;
  logic [CNT_W-1:0]   lit_inc;
  logic               lit_eq;
  logic               append_ok;
  logic               end_ok;

  always_comb begin
    sum        = {1'b0, lit_r} + {1'b0, saved_r} + {{CNT_W{1'b0}}, 1'b1};
    calc       = (sum > (CNT_W+1)'(SCORE_MAX)) ? SCORE_W'(SCORE_MAX) : sum[SCORE_W-1:0];
    pos_ge_len = (pos_r >= len_r);
    pos_inc    = pos_r + 1'b1;
    pos_inc_w  = {1'b0, pos_r} + 1'b1;
    star_last  = (pos_inc_w >= {1'b0, len_r});
    rd_pat     = pos_ge_len ? 8'h00 : fold(rdata_r);
    lit_inc    = (lit_r < CNT_W'(MAX_TEXT)) ? lit_r + 1'b1 : lit_r;
    lit_eq     = (litp_r == uc_r);
    append_ok  = (char_in != 8'h00) && (len_r < POS_W'(MAX_PATTERN));
    end_ok     = (phase_r == PH_DECIDED) ||
                 ((phase_r != PH_FAILED) && ((phase_r == PH_SCAN) || match_r) && pos_ge_len);
  end

  always_comb begin
    len_nxt     = len_r;
    pos_nxt     = pos_r;
    fb_nxt      = fb_r;
    has_fb_nxt  = has_fb_r;
    lit_nxt     = lit_r;
    saved_nxt   = saved_r;
    match_nxt   = match_r;
    after_nxt   = after_r;
    phase_nxt   = phase_r;
    decided_nxt = decided_r;
    steps_nxt   = steps_r;
    uc_nxt      = uc_r;
    litp_nxt    = litp_r;
    omatch_nxt  = omatch_r;
    oscore_nxt  = oscore_r;

    case (cmd.op)
      OP_CLEAR, OP_APPEND, OP_END: begin
        if (cmd.op == OP_CLEAR) len_nxt = '0;
        if (cmd.op == OP_APPEND && append_ok) len_nxt = len_r + 1'b1;
        if (cmd.op == OP_END) begin
          omatch_nxt = end_ok;
          oscore_nxt = !end_ok ? '0 : (phase_r == PH_DECIDED) ? decided_r : calc;
        end
        // every one of these restarts the text match
        pos_nxt     = '0;
        fb_nxt      = '0;
        has_fb_nxt  = 1'b0;
        lit_nxt     = '0;
        saved_nxt   = '0;
        match_nxt   = 1'b0;
        after_nxt   = 1'b0;
        phase_nxt   = PH_NORMAL;
        decided_nxt = '0;
      end
      OP_TEXT: begin
        uc_nxt    = fold(char_in);
        steps_nxt = '0;
      end
      OP_CHK: begin
        steps_nxt = steps_r + 1'b1;
        if (steps_r >= STEP_W'(STEP_LIMIT) || pos_ge_len) phase_nxt = PH_FAILED;
      end
      OP_EV: begin
        case (rdata_r)
          CH_QMARK:  pos_nxt = pos_inc;
          CH_STAR: begin
            pos_nxt = pos_inc;
            if (star_last) begin
              decided_nxt = calc;
              phase_nxt   = PH_DECIDED;
            end else begin
              after_nxt = 1'b1;
            end
          end
          CH_BSLASH: pos_nxt = pos_inc;
          default:   litp_nxt = fold(rdata_r);
        endcase
      end
      OP_QLD: litp_nxt = rd_pat;
      OP_LIT: begin
        if (after_r) begin
          // first literal after a star opens a new fallback point
          saved_nxt  = lit_r;
          fb_nxt     = pos_r;
          has_fb_nxt = 1'b1;
          if (lit_eq) begin
            after_nxt = 1'b0;
            lit_nxt   = CNT_W'(1);
            match_nxt = 1'b1;
            if (!pos_ge_len) pos_nxt = pos_inc;
          end else begin
            lit_nxt   = '0;
            match_nxt = 1'b0;
            phase_nxt = PH_SCAN;
          end
        end else if (!lit_eq) begin
          if (has_fb_r) begin
            lit_nxt = saved_r;
            pos_nxt = (fb_r != '0) ? fb_r - 1'b1 : '0;
          end else begin
            phase_nxt = PH_FAILED;
          end
        end else begin
          lit_nxt   = lit_inc;
          match_nxt = 1'b1;
          if (!pos_ge_len) pos_nxt = pos_inc;
        end
      end
      OP_SEV: begin
        if (rd_pat == uc_r) begin
          phase_nxt = PH_NORMAL;
          after_nxt = 1'b0;
          lit_nxt   = lit_inc;
          match_nxt = 1'b1;
          if (!pos_ge_len) pos_nxt = pos_inc;
        end
      end
      default: ;
    endcase
  end

  // pattern memory: one write, one registered read at the match position
  always_ff @(posedge clk) begin
    if (cmd.op == OP_APPEND && append_ok) mem[len_r[ADDR_W-1:0]] <= char_in;
    rdata_r <= mem[pos_r[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= '0;
      pos_r     <= '0;
      fb_r      <= '0;
      has_fb_r  <= 1'b0;
      lit_r     <= '0;
      saved_r   <= '0;
      match_r   <= 1'b0;
      after_r   <= 1'b0;
      phase_r   <= PH_NORMAL;
      decided_r <= '0;
      steps_r   <= '0;
    end else begin
      len_r     <= len_nxt;
      pos_r     <= pos_nxt;
      fb_r      <= fb_nxt;
      has_fb_r  <= has_fb_nxt;
      lit_r     <= lit_nxt;
      saved_r   <= saved_nxt;
      match_r   <= match_nxt;
      after_r   <= after_nxt;
      phase_r   <= phase_nxt;
      decided_r <= decided_nxt;
      steps_r   <= steps_nxt;
    end
  end

  always_ff @(posedge clk) begin
    uc_r     <= uc_nxt;
    litp_r   <= litp_nxt;
    omatch_r <= omatch_nxt;
    oscore_r <= oscore_nxt;
  end

  always_comb begin
    sts.phase      = phase_r;
    sts.step_over  = (steps_r >= STEP_W'(STEP_LIMIT));
    sts.pos_ge_len = pos_ge_len;
    sts.p_qmark    = (rdata_r == CH_QMARK);
    sts.p_star     = (rdata_r == CH_STAR);
    sts.p_bslash   = (rdata_r == CH_BSLASH);
    sts.star_last  = star_last;
    sts.lit_eq     = lit_eq;
    sts.after_star = after_r;
    sts.has_fb     = has_fb_r;
  end

  assign matched = omatch_r;
  assign score   = oscore_r;

endmodule

// ===== sv/wmsq_ctrl.sv =====
// ----------------------------------------------------------------------------
// wmsq_ctrl
// Sequencer for the matcher: accepts input transactions, walks the pattern
// steps for each text byte and owns the result valid flag.
// ----------------------------------------------------------------------------
module wmsq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [1:0]      in_mode,
  input  logic            char_nz,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  wmsq_pkg::sts_t  sts,
  output wmsq_pkg::cmd_t  cmd
);
  import wmsq_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CHK  = 3'd1;
  localparam logic [2:0] ST_EV   = 3'd2;
  localparam logic [2:0] ST_QRD  = 3'd3;
  localparam logic [2:0] ST_QLD  = 3'd4;
  localparam logic [2:0] ST_LIT  = 3'd5;
  localparam logic [2:0] ST_SEV  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept && in_mode == MODE_END) out_valid_nxt = 1'b1;
    else if (!out_stall)               out_valid_nxt = 1'b0;
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_mode)
            MODE_CLEAR:  cmd.op = OP_CLEAR;
            MODE_APPEND: cmd.op = OP_APPEND;
            MODE_END:    cmd.op = OP_END;
            MODE_TEXT: begin
              if (char_nz && sts.phase == PH_NORMAL) begin
                cmd.op    = OP_TEXT;
                state_nxt = ST_CHK;
              end else if (char_nz && sts.phase == PH_SCAN) begin
                cmd.op    = OP_TEXT;
                state_nxt = ST_SEV;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CHK: begin
        cmd.op    = OP_CHK;
        state_nxt = (sts.step_over || sts.pos_ge_len) ? ST_IDLE : ST_EV;
      end
      ST_EV: begin
        cmd.op = OP_EV;
        if (sts.p_qmark)       state_nxt = ST_IDLE;
        else if (sts.p_star)   state_nxt = sts.star_last ? ST_IDLE : ST_CHK;
        else if (sts.p_bslash) state_nxt = ST_QRD;
        else                   state_nxt = ST_LIT;
      end
      // wait for the read of the quoted byte
      ST_QRD: state_nxt = ST_QLD;
      ST_QLD: begin
        cmd.op    = OP_QLD;
        state_nxt = ST_LIT;
      end
      ST_LIT: begin
        cmd.op = OP_LIT;
        if (!sts.after_star && !sts.lit_eq && sts.has_fb) state_nxt = ST_CHK;
        else                                              state_nxt = ST_IDLE;
      end
      ST_SEV: begin
        cmd.op    = OP_SEV;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== sv/wildcard_match_star_question_score_top.sv =====
// ----------------------------------------------------------------------------
// wildcard_match_star_question_score_top
// Streaming wildcard matcher: loads a pattern with '*', '?' and quoted
// literals, matches text bytes case-insensitively and reports match/score.
//
//   channel | direction | handshake          | fields
//   --------+-----------+--------------------+------------------------------
//   in_     | input     | in_valid/in_stall  | in_mode[1:0], in_char_in[7:0]
//   out_    | output    | out_valid/out_stall| out_matched, out_score[9:0]
//
// Clear/append and end-of-text are handled in idle alone. A text byte walks
// check, evaluate and literal states (check and evaluate for '?'); '*' repeats
// check/evaluate, a backslash adds quoted read and load, a rewind restarts at
// check; bytes after '*' are scanned, after a decided or failed match ignored.
// A result stays in the output register while out_stall is high; a further
// transaction is taken only once the pending result leaves.
// Synchronous active-low reset; pattern memory contents are not cleared.
// ----------------------------------------------------------------------------
module wildcard_match_star_question_score_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_mode,
  input  logic [7:0] in_char_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_matched,
  output logic [9:0] out_score
);
  import wmsq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  wmsq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_mode),
    .char_nz   (in_char_in != 8'h00),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  wmsq_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .char_in (in_char_in),
    .sts     (sts),
    .matched (out_matched),
    .score   (out_score)
  );

endmodule
